FILE: rtl/core/woc_pkg.sv
`default_nettype none

package woc_pkg;

    // Fixed field widths
    localparam int TEMP_W = 15;
    localparam int DIFF_W = 16;   // difference of two 15-bit readings
    localparam int DSQ_W  = 30;   // square of a difference, never reaches 2**30
    localparam int OFS_W  = 16;
    localparam int MEAN_W = 15;
    localparam int THR_W  = 10;

    // Configuration port
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;
    localparam int REG_BIT = 2;   // byte address 4*i, register index in this bit

    typedef enum logic {
        REG_SPREAD_THR = 1'b0,
        REG_INIT_OFS   = 1'b1
    } t_reg_idx;

    localparam logic [THR_W-1:0]        THR_RESET  = 10'd25;
    localparam logic signed [OFS_W-1:0] OFS_RESET  = 16'sd0;
    localparam logic signed [OFS_W-1:0] OFS_MAX    = 16'sd20000;
    localparam logic signed [OFS_W-1:0] OFS_MIN    = -16'sd20000;
    localparam int                      MEAN_MAX   = 16383;
    localparam int                      MEAN_MIN   = -16384;

    typedef struct packed {
        logic ld_in;
        logic ld_diff;
    } t_front_en;

    typedef struct packed {
        logic ld_prod;
        logic ld_cmp;
    } t_judge_en;

    typedef struct packed {
        logic                      done;
        logic                      pass;
        logic signed [MEAN_W-1:0]  mean;
    } t_verdict;

endpackage

`default_nettype wire

FILE: rtl/core/woc_if.sv
`default_nettype none

interface woc_in_if import woc_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [TEMP_W-1:0]  reference_temp;
    logic signed [TEMP_W-1:0]  other_temp;

    modport source (output valid, output reference_temp, output other_temp, input ready);
    modport sink   (input valid, input reference_temp, input other_temp, output ready);
endinterface

interface woc_out_if import woc_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [OFS_W-1:0]   offset;
    logic                      window_done;
    logic                      offset_applied;
    logic signed [MEAN_W-1:0]  window_mean;

    modport source (output valid, output offset, output window_done, output offset_applied,
                    output window_mean, input ready);
    modport sink   (input valid, input offset, input window_done, input offset_applied,
                    input window_mean, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/windowed_offset_calibrator.sv
// Channel   Dir   Request fields                                        Handshake
// i_in      in    reference_temp, other_temp                            valid/ready
// o_out     out   offset, window_done, offset_applied, window_mean      valid/ready
// apb       in    spread_threshold @0x0, initial_offset @0x4            psel/penable/pready
//
// One request per clock sustained while o_out takes results; each request passes through
// the input, difference/square, accumulate, products, compare and offset/output registers.
// Reset is synchronous: accumulators cleared, threshold 25, offset 0; no memory to sweep.
// Each stage advances when the next one is free, so requests keep flowing into empty stages
// while a result waits at o_out; ready drops only in reset or once every stage is full.

`default_nettype none

module windowed_offset_calibrator import woc_pkg::*; #(
    parameter int WINDOW = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    woc_in_if.sink              i_in,
    woc_out_if.source           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SUM_W = DIFF_W + CW;
    localparam int SQ_W  = DSQ_W + CW;
    localparam int THL_W = 2 * THR_W + CW;
    localparam logic [CW-1:0] N_C = CW'(WINDOW);

    localparam int NSTG  = 6;
    localparam int S_IN  = 0;
    localparam int S_DIF = 1;
    localparam int S_ACC = 2;
    localparam int S_PRD = 3;
    localparam int S_CMP = 4;
    localparam int S_OUT = 5;

    logic [NSTG-1:0]             r_vld;
    logic [NSTG-1:0]             n_vld;
    logic [NSTG-1:0]             mv;
    logic                        in_take;
    logic                        ld_out;

    logic                        cfg_wr;
    t_reg_idx                    cfg_idx;
    logic [THR_W-1:0]            r_thr;
    logic signed [OFS_W-1:0]     r_init_ofs;
    logic signed [OFS_W-1:0]     n_init_sat;
    logic signed [OFS_W-1:0]     wr_ofs;
    logic [2*THR_W-1:0]          r_thr_sq;
    logic [THL_W-1:0]            r_thr_lim;

    t_front_en                   front_en;
    t_judge_en                   judge_en;
    logic signed [DIFF_W-1:0]    diff;
    logic [DSQ_W-1:0]            diff_sq;
    logic                        acc_done;
    logic signed [SUM_W-1:0]     acc_sum;
    logic [SQ_W-1:0]             acc_sq;
    t_verdict                    verdict;

    logic signed [OFS_W-1:0]     r_offset;
    logic signed [OFS_W:0]       n_ofs_sum;
    logic signed [OFS_W-1:0]     n_ofs_sat;
    logic signed [OFS_W-1:0]     n_offset;

    logic signed [OFS_W-1:0]     r_out_offset;
    logic                        r_out_done;
    logic                        r_out_applied;
    logic signed [MEAN_W-1:0]    r_out_mean;

    // pipeline flow: a stage moves on when the next stage is empty or moving too
    always_comb begin
        mv[NSTG-1] = r_vld[NSTG-1] && o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            mv[k] = r_vld[k] && (!r_vld[k+1] || mv[k+1]);
        end
    end

    assign i_in.ready = i_rst_n && (!r_vld[S_IN] || mv[S_IN]);
    assign in_take    = i_in.valid && i_in.ready;
    assign n_vld      = {mv[NSTG-2:0], in_take} | (r_vld & ~mv);
    assign ld_out     = mv[S_CMP];

    assign front_en.ld_in   = in_take;
    assign front_en.ld_diff = mv[S_IN];
    assign judge_en.ld_prod = mv[S_ACC];
    assign judge_en.ld_cmp  = mv[S_PRD];

    woc_front u_front (
        .i_clk            (i_clk),
        .i_en             (front_en),
        .i_reference_temp (i_in.reference_temp),
        .i_other_temp     (i_in.other_temp),
        .o_diff           (diff),
        .o_diff_sq        (diff_sq)
    );

    woc_accum #(.WINDOW(WINDOW)) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ld      (mv[S_DIF]),
        .i_diff    (diff),
        .i_diff_sq (diff_sq),
        .o_done    (acc_done),
        .o_sum     (acc_sum),
        .o_sq      (acc_sq)
    );

    woc_judge #(.WINDOW(WINDOW)) u_judge (
        .i_clk     (i_clk),
        .i_en      (judge_en),
        .i_done    (acc_done),
        .i_sum     (acc_sum),
        .i_sq      (acc_sq),
        .i_thr_lim (r_thr_lim),
        .o_verdict (verdict)
    );

    // configuration registers
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[REG_BIT]);
    assign pready  = 1'b1;
    assign wr_ofs  = pwdata[OFS_W-1:0];

    always_comb begin
        if (wr_ofs > OFS_MAX) begin
            n_init_sat = OFS_MAX;
        end else if (wr_ofs < OFS_MIN) begin
            n_init_sat = OFS_MIN;
        end else begin
            n_init_sat = wr_ofs;
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SPREAD_THR: prdata = APB_DW'(r_thr);
            REG_INIT_OFS:   prdata = APB_DW'(r_init_ofs);
            default:        prdata = '0;
        endcase
    end

    // threshold limit N*t*t, registered via r_thr_sq into r_thr_lim after a write
    always_ff @(posedge i_clk) begin
        r_thr_sq  <= (2*THR_W)'(r_thr) * (2*THR_W)'(r_thr);
        r_thr_lim <= THL_W'(r_thr_sq) * THL_W'(N_C);
    end

    // offset update
    assign n_ofs_sum = (OFS_W+1)'(r_offset) + (OFS_W+1)'(verdict.mean);

    always_comb begin
        if (n_ofs_sum > (OFS_W+1)'(OFS_MAX)) begin
            n_ofs_sat = OFS_MAX;
        end else if (n_ofs_sum < (OFS_W+1)'(OFS_MIN)) begin
            n_ofs_sat = OFS_MIN;
        end else begin
            n_ofs_sat = n_ofs_sum[OFS_W-1:0];
        end
    end

    assign n_offset = verdict.pass ? n_ofs_sat : r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_thr      <= THR_RESET;
            r_init_ofs <= OFS_RESET;
            r_offset   <= OFS_RESET;
        end else begin
            r_vld <= n_vld;
            if (ld_out) begin
                r_offset <= n_offset;
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_SPREAD_THR: r_thr <= pwdata[THR_W-1:0];
                    REG_INIT_OFS: begin
                        r_init_ofs <= wr_ofs;
                        r_offset   <= n_init_sat;
                    end
                    default: r_thr <= r_thr;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_offset  <= n_offset;
            r_out_done    <= verdict.done;
            r_out_applied <= verdict.pass;
            r_out_mean    <= verdict.mean;
        end
    end

    assign o_out.valid          = r_vld[S_OUT];
    assign o_out.offset         = r_out_offset;
    assign o_out.window_done    = r_out_done;
    assign o_out.offset_applied = r_out_applied;
    assign o_out.window_mean    = r_out_mean;

    a_open_window_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.window_done |-> !o_out.offset_applied && o_out.window_mean == '0)
        else $error("result of an open window reports an update");

    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ld_out && verdict.pass) && !cfg_wr |=> $stable(r_offset))
        else $error("offset changed without a passing window or a write");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.offset <= OFS_MAX && o_out.offset >= OFS_MIN)
        else $error("offset left its saturation range");

endmodule

`default_nettype wire

FILE: rtl/core/woc_front.sv
`default_nettype none

module woc_front import woc_pkg::*; (
    input  logic                      i_clk,
    input  t_front_en                 i_en,
    input  logic signed [TEMP_W-1:0]  i_reference_temp,
    input  logic signed [TEMP_W-1:0]  i_other_temp,
    output logic signed [DIFF_W-1:0]  o_diff,
    output logic [DSQ_W-1:0]          o_diff_sq
);

    logic signed [TEMP_W-1:0]   r_ref;
    logic signed [TEMP_W-1:0]   r_oth;
    logic signed [DIFF_W-1:0]   n_diff;
    logic signed [2*DIFF_W-1:0] n_prod;
    logic signed [DIFF_W-1:0]   r_diff;
    logic [DSQ_W-1:0]           r_diff_sq;

    assign n_diff = DIFF_W'(r_ref) - DIFF_W'(r_oth);
    assign n_prod = n_diff * n_diff;

    always_ff @(posedge i_clk) begin
        if (i_en.ld_in) begin
            r_ref <= i_reference_temp;
            r_oth <= i_other_temp;
        end
        if (i_en.ld_diff) begin
            r_diff    <= n_diff;
            r_diff_sq <= n_prod[DSQ_W-1:0];
        end
    end

    assign o_diff    = r_diff;
    assign o_diff_sq = r_diff_sq;

endmodule

`default_nettype wire

FILE: rtl/core/woc_accum.sv
`default_nettype none

module woc_accum import woc_pkg::*; #(
    parameter int WINDOW = 20
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_ld,
    input  logic signed [DIFF_W-1:0]                      i_diff,
    input  logic [DSQ_W-1:0]                              i_diff_sq,
    output logic                                          o_done,
    output logic signed [DIFF_W+$clog2(WINDOW+1)-1:0]     o_sum,
    output logic [DSQ_W+$clog2(WINDOW+1)-1:0]             o_sq
);

    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SUM_W = DIFF_W + CW;
    localparam int SQ_W  = DSQ_W + CW;
    localparam int CNT_W = $clog2(WINDOW);

    logic [CNT_W-1:0]         r_cnt;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]          r_sq;
    logic signed [SUM_W-1:0]  n_sum;
    logic [SQ_W-1:0]          n_sq;
    logic                     n_close;
    logic                     r_done;
    logic signed [SUM_W-1:0]  r_tot_sum;
    logic [SQ_W-1:0]          r_tot_sq;

    assign n_sum   = r_sum + SUM_W'(i_diff);
    assign n_sq    = r_sq + SQ_W'(i_diff_sq);
    assign n_close = (r_cnt == CNT_W'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_sq  <= '0;
        end else if (i_ld) begin
            if (n_close) begin
                r_cnt <= '0;
                r_sum <= '0;
                r_sq  <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_sum <= n_sum;
                r_sq  <= n_sq;
            end
        end
    end

    // totals travel on with the item; only a closing item uses them
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_done    <= n_close;
            r_tot_sum <= n_sum;
            r_tot_sq  <= n_sq;
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_tot_sum;
    assign o_sq   = r_tot_sq;

endmodule

`default_nettype wire

FILE: rtl/core/woc_judge.sv
`default_nettype none

module woc_judge import woc_pkg::*; #(
    parameter int WINDOW = 20
) (
    input  logic                                          i_clk,
    input  t_judge_en                                     i_en,
    input  logic                                          i_done,
    input  logic signed [DIFF_W+$clog2(WINDOW+1)-1:0]     i_sum,
    input  logic [DSQ_W+$clog2(WINDOW+1)-1:0]             i_sq,
    input  logic [2*THR_W+$clog2(WINDOW+1)-1:0]           i_thr_lim,
    output t_verdict                                      o_verdict
);

    localparam int CW     = $clog2(WINDOW + 1);
    localparam int SUM_W  = DIFF_W + CW;
    localparam int SQ_W   = DSQ_W + CW;
    localparam int PROD_W = DSQ_W + 2 * CW;
    localparam int THL_W  = 2 * THR_W + CW;
    // rounded mean = floor((2|s| + N) / 2N), done as a reciprocal multiply
    localparam int DIV    = 2 * WINDOW;
    localparam int A_W    = SUM_W + 1;
    localparam int DW     = $clog2(DIV);
    localparam int K      = A_W + DW;
    localparam int MW     = A_W + 2;
    localparam int QP_W   = A_W + MW;
    localparam int Q_W    = DIFF_W;
    localparam longint unsigned RECIP = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [MW-1:0]  RECIP_C   = MW'(RECIP);
    localparam logic [CW-1:0]  N_C       = CW'(WINDOW);
    localparam logic [Q_W-1:0] MAG_P_MAX = Q_W'(MEAN_MAX);
    localparam logic [Q_W-1:0] MAG_N_MAX = Q_W'(-MEAN_MIN);

    logic                        n_neg;
    logic [SUM_W-1:0]            n_abs;
    logic [A_W-1:0]              n_num;
    logic [QP_W-1:0]             n_qprod;
    logic signed [2*SUM_W-1:0]   n_sum_sq;

    logic                        r_done;
    logic                        r_neg;
    logic [Q_W-1:0]              r_qmag;
    logic [PROD_W-1:0]           r_sum_sq;
    logic [PROD_W-1:0]           r_n_sq;

    logic [PROD_W-1:0]           n_lhs;
    logic                        n_pass;
    logic signed [MEAN_W-1:0]    n_mean;
    t_verdict                    r_verdict;

    // products stage
    assign n_neg    = i_sum[SUM_W-1];
    assign n_abs    = n_neg ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign n_num    = {n_abs, 1'b0} + A_W'(WINDOW);
    assign n_qprod  = QP_W'(n_num) * QP_W'(RECIP_C);
    assign n_sum_sq = i_sum * i_sum;

    always_ff @(posedge i_clk) begin
        if (i_en.ld_prod) begin
            r_done   <= i_done;
            r_neg    <= n_neg;
            r_qmag   <= n_qprod[K +: Q_W];
            r_sum_sq <= n_sum_sq[PROD_W-1:0];
            r_n_sq   <= PROD_W'(i_sq) * PROD_W'(N_C);
        end
    end

    // compare stage; N*sum_sq - sum^2 is never negative
    assign n_lhs  = r_n_sq - r_sum_sq;
    assign n_pass = r_done && (n_lhs < PROD_W'(i_thr_lim));

    always_comb begin
        if (!r_done) begin
            n_mean = '0;
        end else if (!r_neg) begin
            n_mean = (r_qmag > MAG_P_MAX) ? MEAN_W'(MEAN_MAX) : MEAN_W'(r_qmag);
        end else begin
            n_mean = (r_qmag > MAG_N_MAX) ? MEAN_W'(MEAN_MIN) : -MEAN_W'(r_qmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_cmp) begin
            r_verdict.done <= r_done;
            r_verdict.pass <= n_pass;
            r_verdict.mean <= n_mean;
        end
    end

    assign o_verdict = r_verdict;

    a_spread_nonneg: assert property (@(posedge i_clk)
        i_en.ld_cmp && r_done |-> r_n_sq >= r_sum_sq)
        else $error("window totals give a negative spread");

    a_open_window_quiet: assert property (@(posedge i_clk)
        i_en.ld_cmp && !r_done |=> !o_verdict.pass && o_verdict.mean == '0)
        else $error("open window produced a verdict");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top import woc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN         = 20;
    localparam int MAX_WAIT    = 18;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic signed [OFS_W-1:0]  offset;
        logic                     window_done;
        logic                     offset_applied;
        logic signed [MEAN_W-1:0] window_mean;
    } calib_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    woc_in_if  in_if ();
    woc_out_if out_if ();

    windowed_offset_calibrator #(.WINDOW(WIN)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Calibrator state as seen from outside
    logic [THR_W-1:0] thr_reg      = THR_RESET;
    logic [OFS_W-1:0] init_ofs_reg = OFS_RESET;
    int               win_count    = 0;
    longint           win_sum      = 0;
    longint           win_sq_sum   = 0;
    longint           offset_acc   = 0;

    calib_result_t offset_reports_due[$];

    int fault_count = 0;
    int cycle_count = 0;
    bit tx_lazy     = 1'b0;
    bit rx_lazy     = 1'b0;
    int rx_hold     = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("windowed_offset_calibrator verification failed");
            $finish;
        end
    end

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic calib_result_t calibrate_step(input logic signed [TEMP_W-1:0] ref_t,
                                                     input logic signed [TEMP_W-1:0] oth_t);
        longint        d;
        longint        lhs;
        longint        rhs;
        longint        mean_v;
        calib_result_t res;
        d = longint'(ref_t) - longint'(oth_t);
        res = '0;
        win_sum    += d;
        win_sq_sum += d * d;
        win_count++;
        if (win_count >= WIN) begin
            lhs = longint'(WIN) * win_sq_sum - win_sum * win_sum;
            rhs = longint'(WIN) * longint'(thr_reg) * longint'(thr_reg);
            // round half away from zero
            if (win_sum >= 0) begin
                mean_v = (2 * win_sum + WIN) / (2 * WIN);
            end else begin
                mean_v = -((-2 * win_sum + WIN) / (2 * WIN));
            end
            mean_v = saturate(mean_v, MEAN_MIN, MEAN_MAX);
            res.window_done = 1'b1;
            if (lhs < rhs) begin
                res.offset_applied = 1'b1;
                offset_acc = saturate(offset_acc + mean_v, longint'(OFS_MIN), longint'(OFS_MAX));
            end
            res.window_mean = mean_v[MEAN_W-1:0];
            win_count  = 0;
            win_sum    = 0;
            win_sq_sum = 0;
        end
        res.offset = offset_acc[OFS_W-1:0];
        return res;
    endfunction

    task automatic push_reading(input logic signed [TEMP_W-1:0] ref_t,
                                input logic signed [TEMP_W-1:0] oth_t);
        int gap;
        gap = tx_lazy ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.reference_temp <= ref_t;
        in_if.other_temp     <= oth_t;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        offset_reports_due.push_back(calibrate_step(ref_t, oth_t));
    endtask

    // Drop valid and wait until every request has produced its result
    task automatic settle_input();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (offset_reports_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(int'(idx) << REG_BIT);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SPREAD_THR: begin
                thr_reg = value[THR_W-1:0];
            end
            REG_INIT_OFS: begin
                init_ofs_reg = value[OFS_W-1:0];
                offset_acc = saturate(longint'($signed(value[OFS_W-1:0])),
                                      longint'(OFS_MIN), longint'(OFS_MAX));
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_reg(input t_reg_idx idx);
        logic [APB_DW-1:0] want;
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'(int'(idx) << REG_BIT);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_SPREAD_THR) begin
            want = APB_DW'(thr_reg);
            got  = APB_DW'(got[THR_W-1:0]);
        end else begin
            want = APB_DW'(init_ofs_reg);
            got  = APB_DW'(got[OFS_W-1:0]);
        end
        if (got !== want) begin
            note_fault($sformatf("register %s read: expected %h, got %h",
                                 idx.name(), want, got));
        end
        @(posedge i_clk);
    endtask

    // One window's worth of requests, aligned to the current window boundary
    task automatic send_window();
        int kind;
        int amp;
        int left;
        int d0;
        int d;
        int lo;
        int hi;
        int oth;
        int i;
        kind = $urandom_range(0, 9);
        left = WIN - win_count;
        d0   = int'($urandom_range(0, 4000)) - 2000;
        amp  = $urandom_range(0, 12);
        if (kind == 5 || kind == 6) begin
            d0  = int'($urandom_range(8000, 32767));
            d0  = $urandom_range(0, 1) ? d0 : -d0;
            amp = $urandom_range(0, 3);
        end else if (kind == 7) begin
            amp = $urandom_range(50, 400);
        end else if (kind == 8) begin
            amp = 0;
        end
        for (i = 0; i < left; i++) begin
            if (kind == 9) begin
                push_reading(TEMP_W'($urandom), TEMP_W'($urandom));
            end else begin
                d = d0 + int'($urandom_range(0, 2 * amp)) - amp;
                // a single +10 lands the window sum on a rounding tie
                if (kind == 8 && i == left - 1) begin
                    d = d0 + 10;
                end
                d   = int'(saturate(d, -32767, 32767));
                lo  = (-16384 - d > -16384) ? -16384 - d : -16384;
                hi  = (16383 - d < 16383) ? 16383 - d : 16383;
                oth = lo + int'($urandom_range(0, hi - lo));
                push_reading(TEMP_W'(oth + d), TEMP_W'(oth));
            end
        end
    endtask

    task automatic test_register_access();
        check_reg(REG_SPREAD_THR);
        check_reg(REG_INIT_OFS);
        write_reg(REG_SPREAD_THR, ($urandom & ~32'h3FF) | 32'd1023);
        check_reg(REG_SPREAD_THR);
        write_reg(REG_INIT_OFS, {16'($urandom), 16'h7FFF});
        check_reg(REG_INIT_OFS);
        write_reg(REG_INIT_OFS, 32'(-20000));
        check_reg(REG_INIT_OFS);
    endtask

    task automatic test_directed_extremes();
        int i;
        tx_lazy = 1'b1;
        rx_lazy = 1'b1;
        write_reg(REG_SPREAD_THR, 32'd1000);
        for (i = 0; i < 10; i++) begin
            push_reading(15'sh3FFF, -15'sh4000);
        end
        // reload the offset mid-window; accumulation carries on
        settle_input();
        write_reg(REG_INIT_OFS, 32'h0000_8000);
        check_reg(REG_INIT_OFS);
        for (i = 10; i < WIN - 1; i++) begin
            push_reading(15'sh3FFF, -15'sh4000);
        end
        push_reading(-15'sh4000, 15'sh3FFF);
        push_reading(15'sd0, 15'sd0);
        push_reading(-15'sd4000, 15'sd8500);
        push_reading(15'sd8500, -15'sd4000);
        push_reading(-15'sd1, 15'sd0);
        settle_input();
    endtask

    task automatic test_backpressure();
        tx_lazy = 1'b0;
        rx_lazy = 1'b0;
        write_reg(REG_SPREAD_THR, 32'd25);
        rx_hold = 80;
        repeat (2) send_window();
        settle_input();
    endtask

    task automatic test_random_windows();
        int               phase;
        int               w;
        logic [THR_W-1:0] thr_pick;
        logic [OFS_W-1:0] ofs_pick;
        for (phase = 0; phase < 7; phase++) begin
            settle_input();
            case (phase)
                0:       thr_pick = '0;
                1:       thr_pick = '1;
                2:       thr_pick = 10'd1000;
                3:       thr_pick = 10'd1;
                4:       thr_pick = 10'd25;
                default: thr_pick = THR_W'($urandom_range(0, 1000));
            endcase
            write_reg(REG_SPREAD_THR, ($urandom & ~32'h3FF) | APB_DW'(thr_pick));
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 4))
                    0:       ofs_pick = 16'h8000;
                    1:       ofs_pick = 16'h7FFF;
                    2:       ofs_pick = OFS_MIN;
                    3:       ofs_pick = OFS_MAX;
                    default: ofs_pick = OFS_W'(int'($urandom_range(0, 40000)) - 20000);
                endcase
                write_reg(REG_INIT_OFS, {16'($urandom), ofs_pick});
            end
            for (w = 0; w < 5; w++) begin
                tx_lazy = $urandom_range(0, 3) != 0;
                rx_lazy = $urandom_range(0, 3) != 0;
                send_window();
            end
        end
        settle_input();
    endtask

    initial begin : result_check
        int            stall;
        calib_result_t got;
        calib_result_t want;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            stall = rx_lazy ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            got.offset         = out_if.offset;
            got.window_done    = out_if.window_done;
            got.offset_applied = out_if.offset_applied;
            got.window_mean    = out_if.window_mean;
            if (offset_reports_due.size() == 0) begin
                note_fault($sformatf("result with nothing pending: offset %0d done %b",
                                     got.offset, got.window_done));
            end else begin
                want = offset_reports_due.pop_front();
                if (got !== want) begin
                    note_fault($sformatf({"offset %0d/%0d done %b/%b applied %b/%b ",
                                          "mean %0d/%0d (expected/actual)"},
                                         want.offset, got.offset,
                                         want.window_done, got.window_done,
                                         want.offset_applied, got.offset_applied,
                                         want.window_mean, got.window_mean));
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.reference_temp <= '0;
        in_if.other_temp     <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_directed_extremes();
        test_backpressure();
        test_random_windows();
        settle_input();
        repeat (20) @(posedge i_clk);
        if (fault_count == 0 && offset_reports_due.size() == 0) begin
            $display("windowed_offset_calibrator verification clean");
        end else begin
            $display("windowed_offset_calibrator verification failed");
        end
        $finish;
    end

endmodule
